### rtl/bbps_pkg.sv
// Package for the beacon blink pattern sequencer.
// Holds action codes, pattern codes, register indexes and reset values.
// No dependencies.
package bbps_pkg;

  localparam int TIME_BITS_DEFAULT = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int DATA_BITS = 32;
  localparam int DELAY_BITS = DATA_BITS + 2;

  localparam logic [1:0] ACT_LEAVE_OFF = 2'd0;
  localparam logic [1:0] ACT_LEAVE_ON  = 2'd1;
  localparam logic [1:0] ACT_TURN_OFF  = 2'd2;
  localparam logic [1:0] ACT_TURN_ON   = 2'd3;

  localparam logic [1:0] PAT_SIMPLE     = 2'd0;
  localparam logic [1:0] PAT_KEYER      = 2'd1;
  localparam logic [1:0] PAT_HEARTBEAT  = 2'd2;
  localparam logic [1:0] PAT_LIGHTHOUSE = 2'd3;

  localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_SELECT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ON_TIME        = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_OFF_TIME       = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_REPEAT_ENABLE  = 2'd3;

  localparam logic [DATA_BITS-1:0] ON_TIME_RESET  = 32'd1000;
  localparam logic [DATA_BITS-1:0] OFF_TIME_RESET = 32'd1000;

  // floor(x / 3) = (x * RECIP3) >> 33 for any 32-bit x
  localparam logic [DATA_BITS-1:0] RECIP3 = 32'hAAAA_AAAB;
  localparam int RECIP3_SHIFT = 33;

  localparam logic [2:0] KEYER_LAST_STEP = 3'd6;

endpackage

### rtl/beacon_blink_pattern_sequencer.sv
// Beacon blink pattern sequencer, top level.
// Depends on bbps_pkg.
//
// Usage:
//   Configuration: cfg_write with cfg_index / cfg_data writes one register
//   (0 pattern_select, 1 on_time, 2 off_time, 3 repeat_enable); write only
//   while no transaction is in flight. Each write takes effect at once.
//   Item channel (item_valid / item_stall): kind 1 arms the selected
//   pattern, kind 0 is a tick carrying now_ms.
//   Result channel (result_valid / result_stall): one action per item,
//   0 leave off, 1 leave on, 2 turn off, 3 turn on.
// Path: an accepted item is stored in the input register, then processed into
//   the result register, where its result is held until the receiver takes it.
// Throughput: one item per clock while the receiver does not stall; the state
//   update is a single add, compare and select between the input register and
//   the result register.
// Stall: while the receiver stalls, one more item is taken into the input
//   register; item_stall then rises until the result register frees up.
// Reset: rst clears both registers, stops the sequencer with the lamp off
//   and restores the register defaults (pattern 0, 1000 ms, 1000 ms, repeat).
module beacon_blink_pattern_sequencer #(
  parameter int TIME_BITS = bbps_pkg::TIME_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [bbps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [bbps_pkg::DATA_BITS-1:0]      cfg_data,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                kind,
  input  logic [31:0]                         now_ms,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [1:0]                          action
);

  localparam int DW = bbps_pkg::DATA_BITS;
  localparam int LW = bbps_pkg::DELAY_BITS;
  localparam int SUMW = (TIME_BITS > LW) ? TIME_BITS : LW;

  logic [1:0]    pattern_select;
  logic [DW-1:0] on_time;
  logic [DW-1:0] on_div3;
  logic [DW-1:0] off_time;
  logic [LW-1:0] off_x3;
  logic          repeat_enable;
  logic [2*DW-1:0] on_prod;

  logic          s1_valid;
  logic          s1_kind;
  logic [31:0]   s1_now;
  logic          s1_go;

  logic                 running;
  logic                 lamp_active;
  logic                 reported_level;
  logic [TIME_BITS-1:0] deadline;
  logic [2:0]           phase_step;

  logic                 running_next;
  logic                 lamp_next;
  logic                 reported_next;
  logic [TIME_BITS-1:0] deadline_next;
  logic [2:0]           phase_next;
  logic [1:0]           action_next;
  logic [LW-1:0]        delay;
  logic [TIME_BITS-1:0] now_t;
  logic [SUMW-1:0]      sum;
  logic                 fire;

  assign on_prod = DW'(cfg_data) * bbps_pkg::RECIP3;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_select <= bbps_pkg::PAT_SIMPLE;
      on_time        <= bbps_pkg::ON_TIME_RESET;
      on_div3        <= bbps_pkg::ON_TIME_RESET / 3;
      off_time       <= bbps_pkg::OFF_TIME_RESET;
      off_x3         <= LW'(bbps_pkg::OFF_TIME_RESET) * 3;
      repeat_enable  <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        bbps_pkg::REG_PATTERN_SELECT: pattern_select <= cfg_data[1:0];
        bbps_pkg::REG_ON_TIME: begin
          on_time <= cfg_data;
          on_div3 <= DW'(on_prod >> bbps_pkg::RECIP3_SHIFT);
        end
        bbps_pkg::REG_OFF_TIME: begin
          off_time <= cfg_data;
          off_x3   <= LW'(cfg_data) + {1'b0, cfg_data, 1'b0};
        end
        bbps_pkg::REG_REPEAT_ENABLE: repeat_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign s1_go      = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && result_valid && result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!item_stall && item_valid) begin
      s1_kind <= kind;
      s1_now  <= now_ms;
    end
  end

  assign now_t = TIME_BITS'(s1_now);
  assign fire  = !(now_t < deadline);

  always_comb begin
    running_next  = running;
    lamp_next     = lamp_active;
    reported_next = reported_level;
    phase_next    = phase_step;
    deadline_next = deadline;
    delay         = LW'(on_time);
    action_next   = bbps_pkg::ACT_LEAVE_OFF;
    sum           = '0;
    if (s1_kind) begin
      running_next  = 1'b1;
      reported_next = 1'b0;
      phase_next    = 3'd0;
      case (pattern_select)
        bbps_pkg::PAT_KEYER: begin
          lamp_next = 1'b1;
          delay     = LW'(on_time >> 2);
        end
        bbps_pkg::PAT_HEARTBEAT: begin
          lamp_next = 1'b1;
          delay     = LW'(on_div3);
        end
        bbps_pkg::PAT_LIGHTHOUSE: begin
          lamp_next = 1'b0;
          delay     = LW'(off_time);
        end
        default: begin
          lamp_next = 1'b1;
          delay     = LW'(on_time);
        end
      endcase
      deadline_next = TIME_BITS'(delay);
      action_next   = bbps_pkg::ACT_LEAVE_OFF;
    end else if (!running) begin
      action_next = lamp_active ? bbps_pkg::ACT_LEAVE_ON : bbps_pkg::ACT_LEAVE_OFF;
    end else begin
      if (fire) begin
        case (pattern_select)
          bbps_pkg::PAT_KEYER: begin
            if (phase_step < bbps_pkg::KEYER_LAST_STEP) begin
              lamp_next  = !lamp_active;
              delay      = LW'(on_time >> 2);
              phase_next = phase_step + 3'd1;
            end else begin
              lamp_next  = 1'b0;
              delay      = LW'(off_time);
              phase_next = 3'd0;
            end
          end
          bbps_pkg::PAT_HEARTBEAT: begin
            case (phase_step)
              3'd0: begin
                lamp_next  = 1'b0;
                delay      = LW'(on_div3 >> 1);
                phase_next = 3'd1;
              end
              3'd1: begin
                lamp_next  = 1'b1;
                delay      = LW'(on_div3);
                phase_next = 3'd2;
              end
              3'd2: begin
                lamp_next  = 1'b0;
                delay      = LW'(off_time);
                phase_next = 3'd3;
              end
              default: begin
                lamp_next  = 1'b1;
                delay      = LW'(on_div3);
                phase_next = 3'd0;
              end
            endcase
          end
          bbps_pkg::PAT_LIGHTHOUSE: begin
            if (phase_step == 3'd0) begin
              lamp_next  = 1'b1;
              delay      = LW'(on_time >> 1);
              phase_next = 3'd1;
            end else begin
              lamp_next  = 1'b0;
              delay      = off_x3;
              phase_next = 3'd0;
            end
          end
          default: begin
            if (lamp_active) begin
              lamp_next = 1'b0;
              delay     = LW'(off_time);
            end else begin
              lamp_next = 1'b1;
              delay     = LW'(on_time);
            end
          end
        endcase
        sum           = SUMW'(now_t) + SUMW'(delay);
        deadline_next = TIME_BITS'(sum);
        // drop out after one simple cycle without repeat
        if (pattern_select == bbps_pkg::PAT_SIMPLE && !lamp_active && !repeat_enable) begin
          running_next = 1'b0;
          lamp_next    = 1'b0;
        end
      end
      if (lamp_next != reported_level) begin
        reported_next = lamp_next;
        action_next   = lamp_next ? bbps_pkg::ACT_TURN_ON : bbps_pkg::ACT_TURN_OFF;
      end else begin
        action_next   = lamp_next ? bbps_pkg::ACT_LEAVE_ON : bbps_pkg::ACT_LEAVE_OFF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running        <= 1'b0;
      lamp_active    <= 1'b0;
      reported_level <= 1'b0;
      deadline       <= '0;
      phase_step     <= 3'd0;
      result_valid   <= 1'b0;
      action         <= bbps_pkg::ACT_LEAVE_OFF;
    end else begin
      if (s1_go) begin
        running        <= running_next;
        lamp_active    <= lamp_next;
        reported_level <= reported_next;
        deadline       <= deadline_next;
        phase_step     <= phase_next;
        result_valid   <= 1'b1;
        action         <= action_next;
      end else if (!result_stall) begin
        result_valid   <= 1'b0;
      end
    end
  end

  a_start_rearms: assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_kind |=> running && !reported_level)
    else $error("start transaction did not re-arm the sequencer");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase_step != 3'd7)
    else $error("phase step out of range");

  a_turn_on_level: assert property (@(posedge clk) disable iff (rst)
    $past(!rst && s1_go) && action == bbps_pkg::ACT_TURN_ON |-> reported_level)
    else $error("turn on reported without lamp level update");

  a_stall_holds_item: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid && result_valid)
    else $error("input stalled with free result register");

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
// Testbench for beacon_blink_pattern_sequencer: a table of directed transactions, then
// random pattern runs, each result checked against the table's action where given, else an in-bench model.
// Depends on bbps_pkg and the sequencer RTL.
module tb;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;
  localparam int   RANDOM_ITEMS = 1750;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

  typedef struct packed {
    row_op_t                             op;
    logic [bbps_pkg::CFG_INDEX_BITS-1:0] reg_idx;
    logic                                item_kind;
    logic [31:0]                         value;
    logic                                typed;
    logic [1:0]                          want;
  } step_row_t;

  localparam step_row_t DIRECTED [0:32] = '{
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'h0000_0000,
      1'b1, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'hFFFF_FFFF,
      1'b1, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_START, 32'h0000_0000,
      1'b1, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'd0,
      1'b1, bbps_pkg::ACT_TURN_ON},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'd999,
      1'b1, bbps_pkg::ACT_LEAVE_ON},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'd1000,
      1'b1, bbps_pkg::ACT_TURN_OFF},
    '{ROW_CFG,  bbps_pkg::REG_REPEAT_ENABLE,  KIND_TICK,  32'd0,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'd2000,
      1'b1, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'd5000,
      1'b1, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_CFG,  bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'(bbps_pkg::PAT_KEYER),
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_CFG,  bbps_pkg::REG_ON_TIME,        KIND_TICK,  32'd8,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_CFG,  bbps_pkg::REG_OFF_TIME,       KIND_TICK,  32'hFFFF_FFFF,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_START, 32'hFFFF_FFFF,
      1'b1, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'd1,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'd2,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'd4,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'hFFFF_FFFF,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'd0,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_CFG,  bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'(bbps_pkg::PAT_HEARTBEAT),
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_CFG,  bbps_pkg::REG_ON_TIME,        KIND_TICK,  32'hFFFF_FFFF,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_CFG,  bbps_pkg::REG_REPEAT_ENABLE,  KIND_TICK,  32'd1,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_START, 32'd0,
      1'b1, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'hFFFF_FFFF,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'h7FFF_FFFF,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_CFG,  bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'(bbps_pkg::PAT_LIGHTHOUSE),
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_CFG,  bbps_pkg::REG_OFF_TIME,       KIND_TICK,  32'hFFFF_FFFF,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_START, 32'd0,
      1'b1, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'hFFFF_FFFE,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'hFFFF_FFFF,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_CFG,  bbps_pkg::REG_ON_TIME,        KIND_TICK,  32'd0,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_CFG,  bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'(bbps_pkg::PAT_SIMPLE),
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'd0,
      1'b0, bbps_pkg::ACT_LEAVE_OFF},
    '{ROW_ITEM, bbps_pkg::REG_PATTERN_SELECT, KIND_TICK,  32'd0,
      1'b0, bbps_pkg::ACT_LEAVE_OFF}
  };

  logic                                clk;
  logic                                rst = 1'b1;
  logic                                cfg_write = 1'b0;
  logic [bbps_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [bbps_pkg::DATA_BITS-1:0]      cfg_data = '0;
  logic                                item_valid = 1'b0;
  logic                                item_stall;
  logic                                kind = KIND_TICK;
  logic [31:0]                         now_ms = '0;
  logic                                result_valid;
  logic                                result_stall = 1'b0;
  logic [1:0]                          action;

  // shadow registers
  logic [1:0]  sel_pattern = bbps_pkg::PAT_SIMPLE;
  logic [31:0] on_ms = bbps_pkg::ON_TIME_RESET;
  logic [31:0] off_ms = bbps_pkg::OFF_TIME_RESET;
  logic        repeat_mode = 1'b1;

  // sequencer state
  logic        seq_running = 1'b0;
  logic        lamp_lit = 1'b0;
  logic        shown_lit = 1'b0;
  logic [31:0] due_ms = '0;
  logic [2:0]  phase_idx = '0;
  logic [7:0]  cycles_done = '0;

  logic [1:0] pending_actions[$];
  logic [1:0] want_action;
  bit         calm = 1'b0;
  int         mismatches = 0;
  int         n_starts = 0;
  int         n_ticks = 0;
  int         n_checked = 0;
  int         n_writes = 0;
  int         act_seen[4] = '{0, 0, 0, 0};
  int         stall_left = 0;
  int         stall_roll;

  beacon_blink_pattern_sequencer u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .kind(kind),
    .now_ms(now_ms),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .action(action)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("beacon_blink_pattern_sequencer verification failed");
    $finish;
  end

  function automatic void bump_cycles();
    if (cycles_done != 8'hFF) cycles_done = cycles_done + 8'd1;
  endfunction

  function automatic logic [1:0] predict_action(input logic is_start, input logic [31:0] t);
    logic keep;
    keep = 1'b1;
    if (is_start) begin
      seq_running = 1'b1;
      shown_lit = 1'b0;
      phase_idx = '0;
      cycles_done = '0;
      case (sel_pattern)
        bbps_pkg::PAT_KEYER: begin
          lamp_lit = 1'b1;
          due_ms = on_ms / 4;
        end
        bbps_pkg::PAT_HEARTBEAT: begin
          lamp_lit = 1'b1;
          due_ms = on_ms / 3;
        end
        bbps_pkg::PAT_LIGHTHOUSE: begin
          lamp_lit = 1'b0;
          due_ms = off_ms;
        end
        default: begin
          lamp_lit = 1'b1;
          due_ms = on_ms;
        end
      endcase
      return bbps_pkg::ACT_LEAVE_OFF;
    end
    if (!seq_running) return lamp_lit ? bbps_pkg::ACT_LEAVE_ON : bbps_pkg::ACT_LEAVE_OFF;
    if (t >= due_ms) begin
      case (sel_pattern)
        bbps_pkg::PAT_KEYER: begin
          if (phase_idx < bbps_pkg::KEYER_LAST_STEP) begin
            lamp_lit = !lamp_lit;
            due_ms = t + on_ms / 4;
            phase_idx = phase_idx + 3'd1;
          end else begin
            lamp_lit = 1'b0;
            due_ms = t + off_ms;
            phase_idx = '0;
            bump_cycles();
          end
        end
        bbps_pkg::PAT_HEARTBEAT: begin
          if (phase_idx == 3'd0) begin
            lamp_lit = 1'b0;
            due_ms = t + on_ms / 6;
            phase_idx = 3'd1;
          end else if (phase_idx == 3'd1) begin
            lamp_lit = 1'b1;
            due_ms = t + on_ms / 3;
            phase_idx = 3'd2;
          end else if (phase_idx == 3'd2) begin
            lamp_lit = 1'b0;
            due_ms = t + off_ms;
            bump_cycles();
            phase_idx = 3'd3;
          end else begin
            lamp_lit = 1'b1;
            due_ms = t + on_ms / 3;
            phase_idx = 3'd0;
          end
        end
        bbps_pkg::PAT_LIGHTHOUSE: begin
          if (phase_idx == 3'd0) begin
            lamp_lit = 1'b1;
            due_ms = t + on_ms / 2;
            phase_idx = 3'd1;
          end else begin
            lamp_lit = 1'b0;
            due_ms = t + off_ms * 32'd3;
            phase_idx = 3'd0;
            bump_cycles();
          end
        end
        default: begin
          if (lamp_lit) begin
            lamp_lit = 1'b0;
            due_ms = t + off_ms;
          end else begin
            lamp_lit = 1'b1;
            due_ms = t + on_ms;
            bump_cycles();
            keep = repeat_mode;
          end
        end
      endcase
    end
    if (!keep && !repeat_mode) begin
      seq_running = 1'b0;
      lamp_lit = 1'b0;
    end
    if (lamp_lit != shown_lit) begin
      shown_lit = lamp_lit;
      return lamp_lit ? bbps_pkg::ACT_TURN_ON : bbps_pkg::ACT_TURN_OFF;
    end
    return lamp_lit ? bbps_pkg::ACT_LEAVE_ON : bbps_pkg::ACT_LEAVE_OFF;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (calm || roll < 60) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [31:0] pick_duration();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 32'd0;
    if (roll < 15) return 32'd1;
    if (roll < 70) return $urandom_range(64, 2);
    if (roll < 80) return $urandom_range(1000, 65);
    if (roll < 88) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("%0t: MISMATCH %s", $time, what);
  endtask

  // hold until every pending transaction has returned
  task automatic settle();
    item_valid <= 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [bbps_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      bbps_pkg::REG_PATTERN_SELECT: sel_pattern = data[1:0];
      bbps_pkg::REG_ON_TIME:        on_ms = data;
      bbps_pkg::REG_OFF_TIME:       off_ms = data;
      bbps_pkg::REG_REPEAT_ENABLE:  repeat_mode = data[0];
      default: ;
    endcase
    n_writes++;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic k, input logic [31:0] t,
                           input logic use_typed, input logic [1:0] typed_act);
    int gap;
    logic [1:0] predicted;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    kind <= k;
    now_ms <= t;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    predicted = predict_action(k, t);
    pending_actions.push_back(use_typed ? typed_act : predicted);
    if (k == KIND_START) n_starts++;
    else n_ticks++;
  endtask

  always @(posedge clk) begin
    if (rst || calm) begin
      stall_left = 0;
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      stall_roll = $urandom_range(99);
      if (stall_roll < 65) begin
        result_stall <= 1'b0;
      end else if (stall_roll < 95) begin
        stall_left = $urandom_range(2, 0);
        result_stall <= 1'b1;
      end else begin
        stall_left = $urandom_range(40, 8);
        result_stall <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_actions.size() == 0) begin
        report_mismatch($sformatf("unexpected result, action %0d", action));
      end else begin
        want_action = pending_actions.pop_front();
        n_checked++;
        if (action !== want_action)
          report_mismatch($sformatf("action got %0d want %0d", action, want_action));
        else
          act_seen[action]++;
      end
    end
  end

  initial begin
    logic [31:0] clock_ms;
    logic [31:0] data;
    int roll;
    int seg_len;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].op == ROW_CFG) begin
        settle();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].value);
      end else begin
        send_item(DIRECTED[i].item_kind, DIRECTED[i].value, DIRECTED[i].typed,
                  DIRECTED[i].want);
      end
    end

    while (n_starts + n_ticks < RANDOM_ITEMS + 22) begin
      settle();
      calm = ($urandom_range(99) < 20);
      data = $urandom_range(1) ? ($urandom & ~32'h3) : 32'h0;
      write_reg(bbps_pkg::REG_PATTERN_SELECT, data | 32'($urandom_range(3)));
      write_reg(bbps_pkg::REG_ON_TIME, pick_duration());
      write_reg(bbps_pkg::REG_OFF_TIME, pick_duration());
      data = $urandom_range(1) ? ($urandom & ~32'h1) : 32'h0;
      write_reg(bbps_pkg::REG_REPEAT_ENABLE, data | 32'($urandom_range(99) < 70));
      if ($urandom_range(99) < 85)
        send_item(KIND_START, $urandom, 1'b0, bbps_pkg::ACT_LEAVE_OFF);
      roll = $urandom_range(99);
      if (roll < 50) clock_ms = 32'd0;
      else if (roll < 75) clock_ms = $urandom_range(100000);
      else if (roll < 90) clock_ms = 32'hFFFF_FFFF - $urandom_range(200);
      else clock_ms = $urandom;
      seg_len = $urandom_range(80, 20);
      repeat (seg_len) begin
        roll = $urandom_range(99);
        if (roll < 3) begin
          send_item(KIND_START, $urandom, 1'b0, bbps_pkg::ACT_LEAVE_OFF);
        end else if (roll < 8) begin
          send_item(KIND_TICK, $urandom, 1'b0, bbps_pkg::ACT_LEAVE_OFF);
        end else if (roll < 9) begin
          send_item(KIND_TICK, 32'hFFFF_FFFF, 1'b0, bbps_pkg::ACT_LEAVE_OFF);
        end else begin
          if (roll < 18) clock_ms = clock_ms + $urandom_range(1200);
          else clock_ms = clock_ms + $urandom_range(40);
          send_item(KIND_TICK, clock_ms, 1'b0, bbps_pkg::ACT_LEAVE_OFF);
        end
        if ($urandom_range(199) == 0) settle();
      end
    end

    calm = 1'b0;
    settle();
    repeat (10) @(posedge clk);
    $display("run: %0d starts, %0d ticks, %0d results checked, %0d register writes",
             n_starts, n_ticks, n_checked, n_writes);
    $display("actions: leave off %0d, leave on %0d, turn off %0d, turn on %0d",
             act_seen[0], act_seen[1], act_seen[2], act_seen[3]);
    if (mismatches == 0) begin
      $display("beacon_blink_pattern_sequencer verification clean");
    end else begin
      $display("beacon_blink_pattern_sequencer verification failed");
    end
    $finish;
  end

endmodule
